/* hw/rtl/rfs_pkg.sv */
// Package for the radio frame segmenter.
// Holds the header constants, beat phase codes and the result beat type.
// No dependencies.
package rfs_pkg;

  localparam int unsigned PayloadW = 7;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PhaseW   = 3;

  localparam logic [PayloadW-1:0] MAX_PAYLOAD_RST = 7'd112;
  localparam logic [PayloadW-1:0] LEN_OVERHEAD    = 7'd5;
  localparam logic [ByteW-1:0]    FC_BYTE0        = 8'h01;
  localparam logic [ByteW-1:0]    FC_BYTE1        = 8'h00;

  // Order in which the beats of one accepted item leave the block.
  localparam logic [PhaseW-1:0] PH_LEN  = 3'd0;
  localparam logic [PhaseW-1:0] PH_FC0  = 3'd1;
  localparam logic [PhaseW-1:0] PH_FC1  = 3'd2;
  localparam logic [PhaseW-1:0] PH_SEQ  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_start;
    logic             frame_end;
    logic             last_of_item;
  } beat_t;

endpackage

/* hw/rtl/radio_frame_segmenter.sv */
// Radio frame segmenter top level: cuts a byte stream into frames with a
// four-byte header (length, frame control, sequence number).
// Depends on rfs_pkg.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_data_byte, in_message_size
//   out      output     out_valid/out_stall out_frame_byte, out_frame_start,
//                                          out_frame_end, out_last_of_item
//   cfg      input      cfg_we             cfg_data (max_payload)
//
// A payload byte inside a frame leaves as a single data beat; the byte that
// opens a frame follows the four header beats through the single output
// register. One item register holds the accepted byte while its beats drain;
// a new byte is taken as the previous data beat leaves. Reset is synchronous
// and clears all control state and sets max_payload to 112. A stall on the
// output holds the output register and, with item beats left, stalls the input.
module radio_frame_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_message_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_start,
  output logic        out_frame_end,
  output logic        out_last_of_item,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  logic [rfs_pkg::PayloadW-1:0] max_payload_r;
  logic [rfs_pkg::SizeW-1:0]    msg_left_r;
  logic [rfs_pkg::PayloadW-1:0] chunk_left_r;
  logic [rfs_pkg::ByteW-1:0]    seq_r;

  // Item register: one accepted byte and the header it opens, if any.
  logic                         pend_valid_r;
  logic [rfs_pkg::PhaseW-1:0]   phase_r;
  logic [rfs_pkg::ByteW-1:0]    pend_byte_r;
  logic [rfs_pkg::PayloadW-1:0] pend_len_r;
  logic [rfs_pkg::ByteW-1:0]    pend_seq_r;
  logic                         pend_end_r;

  logic                         out_valid_r;
  rfs_pkg::beat_t               out_beat_r;

  logic                         in_acc;
  logic                         out_load;
  logic                         idle_msg;
  logic                         drop;
  logic                         hdr;
  logic [rfs_pkg::SizeW-1:0]    msg_cur;
  logic [rfs_pkg::PayloadW-1:0] chunk_cur;
  logic [rfs_pkg::PayloadW-1:0] cap;
  logic [rfs_pkg::PayloadW-1:0] chunk;
  logic [rfs_pkg::PayloadW-1:0] chunk_after;
  logic                         pend_done;
  rfs_pkg::beat_t               beat;

  assign out_load  = !out_valid_r || !out_stall;
  assign pend_done = pend_valid_r && out_load && (phase_r == rfs_pkg::PH_DATA);
  assign in_stall  = pend_valid_r && !pend_done;
  assign in_acc    = in_valid && !in_stall;

  // Frame arithmetic for the incoming byte.
  always_comb begin
    idle_msg  = (msg_left_r == '0);
    drop      = idle_msg && (in_message_size == '0);
    msg_cur   = idle_msg ? in_message_size : msg_left_r;
    chunk_cur = idle_msg ? '0 : chunk_left_r;
    hdr       = (chunk_cur == '0);
    cap       = (max_payload_r == '0) ? 7'd1 : max_payload_r;
    chunk     = (msg_cur > {{(rfs_pkg::SizeW-rfs_pkg::PayloadW){1'b0}}, cap}) ?
                cap : msg_cur[rfs_pkg::PayloadW-1:0];
    chunk_after = (hdr ? chunk : chunk_cur) - 7'd1;
  end

  always_comb begin
    beat = '0;
    case (phase_r)
      rfs_pkg::PH_LEN: begin
        beat.frame_byte  = {1'b0, pend_len_r};
        beat.frame_start = 1'b1;
      end
      rfs_pkg::PH_FC0: beat.frame_byte = rfs_pkg::FC_BYTE0;
      rfs_pkg::PH_FC1: beat.frame_byte = rfs_pkg::FC_BYTE1;
      rfs_pkg::PH_SEQ: beat.frame_byte = pend_seq_r;
      rfs_pkg::PH_DATA: begin
        beat.frame_byte   = pend_byte_r;
        beat.frame_end    = pend_end_r;
        beat.last_of_item = 1'b1;
      end
      default: beat = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= rfs_pkg::MAX_PAYLOAD_RST;
      msg_left_r    <= '0;
      chunk_left_r  <= '0;
      seq_r         <= '0;
      pend_valid_r  <= 1'b0;
      phase_r       <= rfs_pkg::PH_DATA;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= pend_valid_r;
      end
      // A new item is only taken as the previous data beat leaves, so it simply
      // takes over the item register.
      if (in_acc && !drop) begin
        msg_left_r   <= msg_cur - 16'd1;
        chunk_left_r <= chunk_after;
        seq_r        <= seq_r + {{(rfs_pkg::ByteW-1){1'b0}}, hdr};
        pend_valid_r <= 1'b1;
        phase_r      <= hdr ? rfs_pkg::PH_LEN : rfs_pkg::PH_DATA;
      end else if (pend_valid_r && out_load) begin
        if (phase_r == rfs_pkg::PH_DATA) begin
          pend_valid_r <= 1'b0;
        end else begin
          phase_r <= phase_r + 3'd1;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_beat_r <= beat;
    end
    if (in_acc && !drop) begin
      pend_byte_r <= in_data_byte;
      pend_len_r  <= chunk + rfs_pkg::LEN_OVERHEAD;
      pend_seq_r  <= seq_r;
      pend_end_r  <= (chunk_after == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_beat_r.frame_byte;
  assign out_frame_start  = out_beat_r.frame_start;
  assign out_frame_end    = out_beat_r.frame_end;
  assign out_last_of_item = out_beat_r.last_of_item;

`ifndef SYNTH
  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> pend_valid_r)
    else $error("input stalled with an empty item register");

  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_start |-> !out_last_of_item)
    else $error("length byte marked as last beat of its item");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last_of_item)
    else $error("frame end on a header beat");

  a_header_steps: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && out_load && (phase_r == rfs_pkg::PH_LEN)
    |=> pend_valid_r && (phase_r == rfs_pkg::PH_FC0))
    else $error("header beats out of order");

  a_start_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && out_load && (phase_r == rfs_pkg::PH_LEN)
    |=> out_valid && out_frame_start)
    else $error("length byte did not reach the output register");
`endif

endmodule
